### hw/rtl/platform_entity_physics_step_top_defines.svh
// Assertion macros for the entity physics step block.
`ifndef PLATFORM_ENTITY_PHYSICS_STEP_TOP_DEFINES_SVH
`define PLATFORM_ENTITY_PHYSICS_STEP_TOP_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define PEPS_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define PEPS_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### hw/rtl/peps_pkg.sv
// ----------------------------------------------------------------------------
// peps_pkg
// Shared constants and types for the entity physics step block.
// ----------------------------------------------------------------------------
package peps_pkg;
    localparam int unsigned NUM_ENTITIES_DEF = 4;
    localparam int unsigned PW = 20;   // position width
    localparam int unsigned VW = 15;   // speed width
    localparam int unsigned AW = 24;   // signed arithmetic width
    localparam int unsigned DIAG_NUM = 46341;

    localparam logic [2:0] CFG_WW = 3'd0;
    localparam logic [2:0] CFG_WH = 3'd1;
    localparam logic [2:0] CFG_GR = 3'd2;
    localparam logic [2:0] CFG_JS = 3'd3;
    localparam logic [2:0] CFG_FL = 3'd4;
    localparam logic [2:0] CFG_WS = 3'd5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Sweep request from the sequencer to the sweep unit.
    typedef struct packed {
        logic                 up;     // move > 0
        logic signed [AW-1:0] allowed;
        logic signed [AW-1:0] mlo;
        logic signed [AW-1:0] mhi;
        logic signed [AW-1:0] plo;
        logic signed [AW-1:0] phi;
    } t_sweep_in;

    // Other entity box projected on the sweep axis.
    typedef struct packed {
        logic                 blk;
        logic signed [AW-1:0] olo;
        logic signed [AW-1:0] ohi;
        logic signed [AW-1:0] qlo;
        logic signed [AW-1:0] qhi;
    } t_sweep_obj;
endpackage

### hw/rtl/peps_sweep_unit.sv
// ----------------------------------------------------------------------------
// peps_sweep_unit
// Shared compare unit: narrows the allowed move against one other box.
// ----------------------------------------------------------------------------
module peps_sweep_unit
    import peps_pkg::*;
(
    input  t_sweep_in             i_req,
    input  t_sweep_obj            i_obj,
    output logic signed [AW-1:0]  o_allowed
);
    logic                 meet;
    logic signed [AW-1:0] gap_up;
    logic signed [AW-1:0] gap_dn;

    always_comb begin
        meet   = !(i_req.phi <= i_obj.qlo) && !(i_req.plo >= i_obj.qhi);
        gap_up = i_obj.olo - i_req.mhi;
        gap_dn = i_obj.ohi - i_req.mlo;
        o_allowed = i_req.allowed;
        if (i_obj.blk && meet) begin
            if (i_req.up) begin
                if (i_obj.olo >= i_req.mhi && gap_up < i_req.allowed) begin
                    o_allowed = gap_up;
                end
            end else begin
                if (i_obj.ohi <= i_req.mlo && gap_dn > i_req.allowed) begin
                    o_allowed = gap_dn;
                end
            end
        end
    end
endmodule

### hw/rtl/platform_entity_physics_step_top.sv
// ----------------------------------------------------------------------------
// platform_entity_physics_step_top
// Entity table with a sequencer that steps one entity per request beat.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Beat
// request | in        | i_valid / o_ready  | load or step of one entity
// result  | out       | o_valid / i_ready  | new entity state and frame flags
// config  | in        | i_cfg_we           | one register write, no wait
//
// A load holds the block: the result is valid in the cycle after the request
// beat, and the next request is taken the cycle after the result beat. A step
// runs S_PREP, S_SWX, S_GRAV, S_SWY, S_DONE, S_CLAMP; each of the two sweeps
// visits every table entry once through the single shared compare unit, and a
// god mode step goes from S_PREP straight to S_CLAMP. Reset is synchronous,
// active low, clears the table and loads the register defaults. A stalled
// result is held in the output register; the next request waits for its beat.
module platform_entity_physics_step_top
    import peps_pkg::*;
#(
    parameter int unsigned NUM_ENTITIES = NUM_ENTITIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [13:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_req_type,
    input  logic [5:0]            i_entity_index,
    input  logic [19:0]           i_load_x,
    input  logic [19:0]           i_load_y,
    input  logic [9:0]            i_box_width,
    input  logic [9:0]            i_box_height,
    input  logic [2:0]            i_entity_flags,
    input  logic [5:0]            i_key_mask,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [5:0]            o_out_index,
    output logic [19:0]           o_new_x,
    output logic [19:0]           o_new_y,
    output logic signed [14:0]    o_new_speed_y,
    output logic                  o_on_ground,
    output logic                  o_in_air,
    output logic                  o_sprinting,
    output logic                  o_hit_entity,
    output logic                  o_hit_world,
    output logic                  o_collision_state
);
    localparam int unsigned IW = (NUM_ENTITIES > 1) ? $clog2(NUM_ENTITIES) : 1;
    localparam int unsigned CW = $clog2(NUM_ENTITIES + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_SWX   = 3'd2;
    localparam logic [2:0] S_GRAV  = 3'd3;
    localparam logic [2:0] S_SWY   = 3'd4;
    localparam logic [2:0] S_CLAMP = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // configuration
    logic [11:0] r_ww, r_wh, r_ws;
    logic [10:0] r_gr;
    logic [13:0] r_js, r_fl;

    // entity table, one register per entry
    logic [PW-1:0] r_px [NUM_ENTITIES];
    logic [PW-1:0] r_py [NUM_ENTITIES];
    logic [VW-1:0] r_vy [NUM_ENTITIES];
    logic [9:0]    r_bw [NUM_ENTITIES];
    logic [9:0]    r_bh [NUM_ENTITIES];
    logic [2:0]    r_md [NUM_ENTITIES];
    logic [2:0]    r_gj [NUM_ENTITIES];

    logic [2:0]            r_st;
    logic [IW-1:0]         r_e;
    logic [CW-1:0]         r_cnt;
    logic [5:0]            r_keys;
    logic signed [AW-1:0]  r_x, r_y, r_v, r_want, r_allow, r_hw, r_hh, r_cur;
    logic                  r_gnd, r_air, r_was, r_spr, r_hite, r_hitw;

    logic                  r_ov;
    logic [5:0]            r_oidx;
    logic [19:0]           r_ox, r_oy;
    logic [14:0]           r_ovy;
    logic [5:0]            r_ofl;

    assign o_ready = (r_st == S_IDLE) && !r_ov;
    wire acc = i_valid && o_ready;
    wire in_rng = {26'd0, i_entity_index} < NUM_ENTITIES;

    // sweep unit operands
    t_sweep_in             sw_req;
    t_sweep_obj            sw_obj;
    logic signed [AW-1:0]  sw_out;
    logic [IW-1:0]         oi;
    logic signed [AW-1:0]  ohw, ohh, ox, oy;

    always_comb begin
        oi  = r_cnt[IW-1:0];
        ohw = AW'({r_bw[oi], 7'd0});
        ohh = AW'({r_bh[oi], 7'd0});
        ox  = AW'(r_px[oi]);
        oy  = AW'(r_py[oi]);
        sw_req.up      = r_want > 0;
        sw_req.allowed = r_allow;
        sw_obj.blk     = r_md[oi][1] && (oi != r_e);
        if (r_st == S_SWX) begin
            sw_req.mlo = r_x - r_hw; sw_req.mhi = r_x + r_hw;
            sw_req.plo = r_y - r_hh; sw_req.phi = r_y + r_hh;
            sw_obj.olo = ox - ohw;   sw_obj.ohi = ox + ohw;
            sw_obj.qlo = oy - ohh;   sw_obj.qhi = oy + ohh;
        end else begin
            sw_req.mlo = r_y - r_hh; sw_req.mhi = r_y + r_hh;
            sw_req.plo = r_x - r_hw; sw_req.phi = r_x + r_hw;
            sw_obj.olo = oy - ohh;   sw_obj.ohi = oy + ohh;
            sw_obj.qlo = ox - ohw;   sw_obj.qhi = ox + ohw;
        end
    end

    peps_sweep_unit u_sweep (
        .i_req     (sw_req),
        .i_obj     (sw_obj),
        .o_allowed (sw_out)
    );

    // step preparation from the latched entry
    logic                 ctrl, jdn;
    logic signed [1:0]    ixs, iys;
    logic signed [AW-1:0] cur2, mag;
    logic [31:0]          dprod;
    logic signed [AW-1:0] vg, cx, cy, cv, wwq, whq;
    logic                 cg, ca, ch;

    always_comb begin
        ctrl = r_md[r_e][0];
        ixs = 2'sd0; iys = 2'sd0;
        if (ctrl) begin
            if (r_keys[1]) ixs = 2'sd1; else if (r_keys[0]) ixs = -2'sd1;
            if (r_md[r_e][2]) begin
                if (r_keys[3]) iys = -2'sd1; else if (r_keys[2]) iys = 2'sd1;
            end
        end
        cur2 = (ctrl && r_keys[4]) ? AW'({r_ws, 1'b0}) : AW'(r_ws);
        dprod = 32'(cur2[12:0]) * 32'(DIAG_NUM) + 32'd32768;
        mag = (ixs != 0 && iys != 0) ? AW'(dprod[31:16]) : cur2;
        jdn = ctrl && r_keys[5];

        // gravity, then hold at the terminal speed
        vg = r_v - AW'(r_gr);
        if (vg < -$signed(AW'(r_fl))) vg = -$signed(AW'(r_fl));

        // window clamp
        wwq = AW'({r_ww, 8'd0});
        whq = AW'({r_wh, 8'd0});
        cx = r_x; cy = r_y; cv = r_v; cg = r_gnd; ca = r_air; ch = 1'b0;
        if (cx - r_hw < 0) begin cx = r_hw; ch = 1'b1; end
        if (cx + r_hw > wwq) begin cx = wwq - r_hw; ch = 1'b1; end
        if (cy - r_hh < 0) begin
            cy = r_hh; ch = 1'b1; cg = 1'b1; ca = 1'b0;
            if (cv < 0) cv = '0;
        end
        if (cy + r_hh > whq) begin
            cy = whq - r_hh; ch = 1'b1;
            if (cv > 0) cv = '0;
        end
    end

    function automatic logic [19:0] sat_pos(input logic signed [AW-1:0] v);
        logic [19:0] r;
        if (v < 0) r = '0;
        else if (v > 24'sd1048575) r = 20'hFFFFF;
        else r = v[19:0];
        return r;
    endfunction

    wire [CW-1:0] last = CW'(NUM_ENTITIES - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ww <= 12'd1600; r_wh <= 12'd900; r_gr <= 11'd154;
            r_js <= 14'd4608; r_fl <= 14'd7168; r_ws <= 12'd1280;
            r_st <= S_IDLE; r_ov <= 1'b0;
            for (int i = 0; i < NUM_ENTITIES; i++) begin
                r_px[i] <= '0; r_py[i] <= '0; r_vy[i] <= '0;
                r_bw[i] <= '0; r_bh[i] <= '0; r_md[i] <= '0; r_gj[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WW:  r_ww <= i_cfg_data[11:0];
                    CFG_WH:  r_wh <= i_cfg_data[11:0];
                    CFG_GR:  r_gr <= i_cfg_data[10:0];
                    CFG_JS:  r_js <= i_cfg_data;
                    CFG_FL:  r_fl <= i_cfg_data;
                    CFG_WS:  r_ws <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (acc) begin
                        r_oidx <= i_entity_index;
                        r_e    <= i_entity_index[IW-1:0];
                        r_keys <= i_key_mask;
                        if (!in_rng) begin
                            // out of range: zero result, table untouched
                            r_ox <= '0; r_oy <= '0; r_ovy <= '0; r_ofl <= '0;
                            r_ov <= 1'b1;
                        end else if (i_req_type == REQ_LOAD) begin
                            r_px[i_entity_index[IW-1:0]] <= i_load_x;
                            r_py[i_entity_index[IW-1:0]] <= i_load_y;
                            r_bw[i_entity_index[IW-1:0]] <= i_box_width;
                            r_bh[i_entity_index[IW-1:0]] <= i_box_height;
                            r_md[i_entity_index[IW-1:0]] <= i_entity_flags;
                            r_vy[i_entity_index[IW-1:0]] <= '0;
                            r_gj[i_entity_index[IW-1:0]] <= '0;
                            r_ox <= i_load_x; r_oy <= i_load_y;
                            r_ovy <= '0; r_ofl <= '0;
                            r_ov <= 1'b1;
                        end else begin
                            r_st <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_hw  <= AW'({r_bw[r_e], 7'd0});
                    r_hh  <= AW'({r_bh[r_e], 7'd0});
                    r_spr <= ctrl && r_keys[4] && (ixs != 0 || iys != 0);
                    r_hite <= 1'b0;
                    r_cnt <= '0;
                    r_gnd <= r_gj[r_e][0];
                    r_air <= r_gj[r_e][1];
                    if (r_md[r_e][2]) begin
                        // free move, then clamp only
                        r_x <= AW'(r_px[r_e]) + AW'(ixs) * mag;
                        r_y <= AW'(r_py[r_e]) + AW'(iys) * mag;
                        r_v <= AW'(signed'(r_vy[r_e]));
                        r_was <= r_gj[r_e][2];
                        r_st <= S_CLAMP;
                    end else begin
                        r_x <= AW'(r_px[r_e]);
                        r_y <= AW'(r_py[r_e]);
                        if (jdn && !r_gj[r_e][2] && r_gj[r_e][0]) begin
                            r_v <= AW'(r_js);
                        end else begin
                            r_v <= AW'(signed'(r_vy[r_e]));
                        end
                        r_was  <= jdn;
                        r_want <= AW'(ixs) * cur2;
                        r_allow <= AW'(ixs) * cur2;
                        r_st <= S_SWX;
                    end
                end
                S_SWX: begin
                    if (r_want != 0) r_allow <= sw_out;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == last) r_st <= S_GRAV;
                end
                S_GRAV: begin
                    if (r_allow != r_want) r_hite <= 1'b1;
                    r_x <= r_x + r_allow;
                    r_v <= vg; r_want <= vg; r_allow <= vg;
                    r_gnd <= 1'b0; r_air <= 1'b1;
                    r_cnt <= '0;
                    r_st <= S_SWY;
                end
                S_SWY: begin
                    if (r_want != 0) r_allow <= sw_out;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == last) r_st <= S_DONE;
                end
                S_DONE: begin
                    // vertical sweep outcome
                    if (r_allow != r_want) begin
                        if (r_want < 0) begin r_gnd <= 1'b1; r_air <= 1'b0; end
                        else if (r_want > 0) r_hite <= 1'b1;
                        r_v <= '0;
                    end
                    r_y <= r_y + r_allow;
                    r_st <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_px[r_e] <= sat_pos(cx);
                    r_py[r_e] <= sat_pos(cy);
                    r_vy[r_e] <= cv[VW-1:0];
                    r_gj[r_e] <= {r_was, ca, cg};
                    r_ox <= sat_pos(cx); r_oy <= sat_pos(cy); r_ovy <= cv[VW-1:0];
                    r_ofl <= {r_hite, ch, r_hite, r_spr, ca, cg};
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ov;
    assign o_out_index       = r_oidx;
    assign o_new_x           = r_ox;
    assign o_new_y           = r_oy;
    assign o_new_speed_y     = signed'(r_ovy);
    assign o_on_ground       = r_ofl[0];
    assign o_in_air          = r_ofl[1];
    assign o_sprinting       = r_ofl[2];
    assign o_hit_entity      = r_ofl[3];
    assign o_hit_world       = r_ofl[4];
    assign o_collision_state = r_ofl[5];
endmodule

### hw/rtl/peps_checker.sv
// ----------------------------------------------------------------------------
// peps_checker
// Port-level checks for the entity physics step block.
// ----------------------------------------------------------------------------
`include "platform_entity_physics_step_top_defines.svh"
module peps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_hit_entity,
    input logic       o_collision_state,
    input logic       o_on_ground,
    input logic       o_in_air
);
    // hold a stalled result
    `PEPS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // no new request while a result waits
    `PEPS_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_valid, !o_ready)
    // collision flag follows the entity hit
    `PEPS_ASSERT_IMP(a_coll, i_clk, i_rst_n, o_valid, o_collision_state == o_hit_entity)
    // never grounded and airborne at once
    `PEPS_ASSERT_IMP(a_gnd, i_clk, i_rst_n, o_valid, !(o_on_ground && o_in_air))
endmodule

bind platform_entity_physics_step_top peps_checker u_peps_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_hit_entity      (o_hit_entity),
    .o_collision_state (o_collision_state),
    .o_on_ground       (o_on_ground),
    .o_in_air          (o_in_air)
);

### dv/tb.sv
// ----------------------------------------------------------------------------
// Entity physics step testbench
// Drives load and step beats into the entity table, predicts every result
// beat from a behavioral copy of the table and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import peps_pkg::*;

    localparam int NENT = int'(NUM_ENTITIES_DEF);
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [5:0]         idx;
        logic [19:0]        x;
        logic [19:0]        y;
        logic signed [14:0] vy;
        logic               gnd;
        logic               air;
        logic               sprint;
        logic               hit_ent;
        logic               hit_w;
        logic               coll;
    } phys_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [13:0] cfg_data = '0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic req_type = 1'b0;
    logic [5:0] ent_idx = '0;
    logic [19:0] ld_x = '0, ld_y = '0;
    logic [9:0] bw = '0, bh = '0;
    logic [2:0] eflags = '0;
    logic [5:0] keys = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    phys_result_t got;

    platform_entity_physics_step_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_req_type(req_type), .i_entity_index(ent_idx),
        .i_load_x(ld_x), .i_load_y(ld_y),
        .i_box_width(bw), .i_box_height(bh),
        .i_entity_flags(eflags), .i_key_mask(keys),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_out_index(got.idx), .o_new_x(got.x), .o_new_y(got.y),
        .o_new_speed_y(got.vy), .o_on_ground(got.gnd), .o_in_air(got.air),
        .o_sprinting(got.sprint), .o_hit_entity(got.hit_ent),
        .o_hit_world(got.hit_w), .o_collision_state(got.coll)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the block's registers and entity table.
    longint world_w, world_h, grav, jump_v, fall_lim, walk_v;
    longint px [NENT], py [NENT], pvy [NENT];
    int bwid [NENT], bhgt [NENT];
    bit [2:0] mode [NENT];
    bit gnd_t [NENT], air_t [NENT], jmp_t [NENT];

    phys_result_t expected_q[$];
    int errors = 0;
    int results_seen = 0;
    longint cycles = 0;
    bit quiet = 1'b0;   // no idling in the closing part of the run
    bit sink_on = 1'b0;

    function automatic longint half_w(int i);
        return longint'(bwid[i]) * 128;
    endfunction
    function automatic longint half_h(int i);
        return longint'(bhgt[i]) * 128;
    endfunction

    // Trim a move along one axis against every other blocking box.
    function automatic longint sweep_move(int self, bit along_y, longint mv,
                                          longint x, longint y);
        longint allowed, mlo, mhi, plo, phi, olo, ohi, qlo, qhi;
        allowed = mv;
        if (mv == 0) return 0;
        if (!along_y) begin
            mlo = x - half_w(self); mhi = x + half_w(self);
            plo = y - half_h(self); phi = y + half_h(self);
        end else begin
            mlo = y - half_h(self); mhi = y + half_h(self);
            plo = x - half_w(self); phi = x + half_w(self);
        end
        for (int i = 0; i < NENT; i++) begin
            if (i == self || !mode[i][1]) continue;
            if (!along_y) begin
                olo = px[i] - half_w(i); ohi = px[i] + half_w(i);
                qlo = py[i] - half_h(i); qhi = py[i] + half_h(i);
            end else begin
                olo = py[i] - half_h(i); ohi = py[i] + half_h(i);
                qlo = px[i] - half_w(i); qhi = px[i] + half_w(i);
            end
            if (phi <= qlo || plo >= qhi) continue;
            if (mv > 0) begin
                if (olo >= mhi && olo - mhi < allowed) allowed = olo - mhi;
            end else begin
                if (ohi <= mlo && ohi - mlo > allowed) allowed = ohi - mlo;
            end
        end
        return allowed;
    endfunction

    function automatic bit window_clamp(int e, ref longint x, ref longint y,
                                        ref longint vy, ref bit g, ref bit a);
        bit hit;
        longint hw, hh;
        hit = 0; hw = half_w(e); hh = half_h(e);
        if (x - hw < 0) begin x = hw; hit = 1; end
        if (x + hw > world_w * 256) begin x = world_w * 256 - hw; hit = 1; end
        if (y - hh < 0) begin
            y = hh; hit = 1; g = 1; a = 0;
            if (vy < 0) vy = 0;
        end
        if (y + hh > world_h * 256) begin
            y = world_h * 256 - hh; hit = 1;
            if (vy > 0) vy = 0;
        end
        return hit;
    endfunction

    function automatic logic [19:0] sat20(longint v);
        if (v < 0) return '0;
        if (v > 1048575) return 20'hFFFFF;
        return v[19:0];
    endfunction

    // Apply one beat to the shadow table and return the frame it produces.
    function automatic phys_result_t physics_frame(bit rt, int idx, logic [19:0] lx,
            logic [19:0] ly, int w, int h, bit [2:0] fl, bit [5:0] km);
        phys_result_t r;
        longint x, y, vy, ix, iy, cur, mag, want, moved;
        bit ctrl, god, g, a, was, jd, spr, he, hw;
        r = '0; r.idx = idx[5:0];
        ix = 0; iy = 0; spr = 0; he = 0; hw = 0;
        if (idx >= NENT) return r;
        if (rt == REQ_LOAD) begin
            px[idx] = lx; py[idx] = ly; bwid[idx] = w; bhgt[idx] = h;
            mode[idx] = fl; pvy[idx] = 0;
            gnd_t[idx] = 0; air_t[idx] = 0; jmp_t[idx] = 0;
            r.x = lx; r.y = ly;
            return r;
        end
        x = px[idx]; y = py[idx]; vy = pvy[idx];
        ctrl = mode[idx][0]; god = mode[idx][2];
        g = gnd_t[idx]; a = air_t[idx]; was = jmp_t[idx];
        if (ctrl) begin
            if (km[1]) ix = 1; else if (km[0]) ix = -1;
            if (god) begin
                if (km[3]) iy = -1; else if (km[2]) iy = 1;
            end
        end
        cur = walk_v;
        if (ctrl && km[4]) begin
            cur = cur * 2;
            if (ix != 0 || iy != 0) spr = 1;
        end
        if (god) begin
            mag = cur;
            if (ix != 0 && iy != 0) mag = (cur * DIAG_NUM + 32768) >>> 16;
            x += ix * mag; y += iy * mag;
            hw = window_clamp(idx, x, y, vy, g, a);
        end else begin
            jd = ctrl && km[5];
            if (jd && !was && g) begin vy = jump_v; g = 0; a = 1; end
            was = jd;
            want = ix * cur;
            moved = sweep_move(idx, 0, want, x, y);
            if (moved != want) he = 1;
            x += moved;
            vy -= grav;
            if (vy < -fall_lim) vy = -fall_lim;
            g = 0; a = 1;
            want = vy;
            moved = sweep_move(idx, 1, want, x, y);
            if (moved != want) begin
                if (want < 0) begin g = 1; a = 0; end
                else if (want > 0) he = 1;
                vy = 0;
            end
            y += moved;
            hw = window_clamp(idx, x, y, vy, g, a);
        end
        px[idx] = sat20(x); py[idx] = sat20(y);
        // wrap to the 15-bit stored speed, as the table keeps it
        vy = longint'($signed(vy[14:0]));
        pvy[idx] = vy;
        gnd_t[idx] = g; air_t[idx] = a; jmp_t[idx] = was;
        r.x = px[idx]; r.y = py[idx]; r.vy = vy[14:0];
        r.gnd = g; r.air = a; r.sprint = spr;
        r.hit_ent = he; r.hit_w = hw; r.coll = he;
        return r;
    endfunction

    // Send one request beat; hold valid and payload until accepted. Valid
    // stays high after the beat and drops only when an idle gap or a drain follows.
    task automatic send_beat(bit rt, int idx, logic [19:0] lx, logic [19:0] ly,
                             int w, int h, bit [2:0] fl, bit [5:0] km);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1; req_type <= rt; ent_idx <= idx[5:0];
        ld_x <= lx; ld_y <= ly; bw <= w[9:0]; bh <= h[9:0];
        eflags <= fl; keys <= km;
        expected_q.push_back(physics_frame(rt, idx, lx, ly, w, h, fl, km));
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic load_entity(int idx, longint x, longint y, int w, int h, bit [2:0] fl);
        send_beat(REQ_LOAD, idx, x[19:0], y[19:0], w, h, fl, 6'($urandom));
    endtask

    task automatic step_entity(int idx, bit [5:0] km);
        send_beat(REQ_STEP, idx, 20'($urandom), 20'($urandom),
                  $urandom_range(0, 1023), $urandom_range(0, 1023), 3'($urandom), km);
    endtask

    // Drop valid, wait for every pending result plus slack.
    task automatic drain();
        req_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write one register; the enable stays high for back-to-back writes.
    task automatic write_reg(logic [2:0] ridx, longint val);
        cfg_we <= 1'b1; cfg_index <= ridx; cfg_data <= val[13:0];
        @(posedge clk);
        case (ridx)
            CFG_WW: world_w = val & 12'hFFF;
            CFG_WH: world_h = val & 12'hFFF;
            CFG_GR: grav = val & 11'h7FF;
            CFG_JS: jump_v = val & 14'h3FFF;
            CFG_FL: fall_lim = val & 14'h3FFF;
            CFG_WS: walk_v = val & 12'hFFF;
            default: ;
        endcase
    endtask

    task automatic set_physics(longint ww, longint wh, longint gr, longint js,
                               longint fl, longint ws);
        drain();
        write_reg(CFG_WW, ww); write_reg(CFG_WH, wh); write_reg(CFG_GR, gr);
        write_reg(CFG_JS, js); write_reg(CFG_FL, fl); write_reg(CFG_WS, ws);
        cfg_we <= 1'b0;
    endtask

    // Extremes of every load field, out-of-range indexes and key corners.
    task automatic test_directed();
        load_entity(0, 0, 0, 1, 1, 3'b000);
        load_entity(1, 20'hFFFFF, 20'hFFFFF, 1023, 1023, 3'b111);
        load_entity(4, 5000, 5000, 8, 8, 3'b011);
        load_entity(63, 20'hFFFFF, 0, 1023, 1, 3'b101);
        step_entity(63, 6'h3F);
        step_entity(2, 6'h00);
        step_entity(1, 6'b010101);    // god, left+up with sprint
        step_entity(1, 6'b011010);    // god, right+down with sprint
        step_entity(1, 6'b001111);    // god, all four directions
        // floor: land, then jump once per key edge
        load_entity(0, 400 * 256, 100 * 256, 32, 32, 3'b001);
        for (int i = 0; i < 4; i++) step_entity(0, 6'h00);
        step_entity(0, 6'b100000);
        step_entity(0, 6'b100000);
        step_entity(0, 6'b010010);
        // blocking neighbor to the right and a ceiling
        load_entity(2, 420 * 256, 100 * 256, 8, 200, 3'b010);
        load_entity(3, 400 * 256, 150 * 256, 64, 8, 3'b010);
        step_entity(0, 6'b000010);
        step_entity(0, 6'b110010);
        step_entity(0, 6'b000001);
        // box taller than the window
        load_entity(3, 300 * 256, 300 * 256, 1023, 1023, 3'b000);
        step_entity(3, 6'h00);
    endtask

    // Mostly controlled entities in a small crowded area with random keys.
    task automatic test_random(int n);
        int idx;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                idx = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 63)
                                                   : $urandom_range(0, 3);
                if ($urandom_range(0, 19) == 0)
                    load_entity(idx, 20'($urandom), 20'($urandom),
                                $urandom_range(1, 1023), $urandom_range(1, 1023),
                                3'($urandom));
                else
                    load_entity(idx, $urandom_range(0, 256 * 256),
                                $urandom_range(0, 128 * 256),
                                $urandom_range(1, 64), $urandom_range(1, 64),
                                3'($urandom) | 3'b001);
            end else begin
                idx = ($urandom_range(0, 31) == 0) ? $urandom_range(4, 63)
                                                   : $urandom_range(0, 3);
                step_entity(idx, 6'($urandom));
            end
        end
    endtask

    // Result side: random stalls, compare each beat with the oldest frame.
    always @(posedge clk) begin
        phys_result_t exp_r;
        cycles <= cycles + 1;
        res_ready <= sink_on && (quiet ? 1'b1 : ($urandom_range(0, 5) != 0));
        if (rst_n && res_valid && res_ready) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
                errors <= errors + 1;
                $display("%0t: unexpected result beat idx %0d", $time, got.idx);
            end else begin
                exp_r = expected_q.pop_front();
                if (exp_r !== got) begin
                    errors <= errors + 1;
                    $display("%0t: mismatch expected idx %0d x %h y %h vy %0d g%b a%b s%b he%b hw%b c%b",
                             $time, exp_r.idx, exp_r.x, exp_r.y, exp_r.vy, exp_r.gnd,
                             exp_r.air, exp_r.sprint, exp_r.hit_ent, exp_r.hit_w,
                             exp_r.coll);
                    $display("%0t: mismatch actual   idx %0d x %h y %h vy %0d g%b a%b s%b he%b hw%b c%b",
                             $time, got.idx, got.x, got.y, got.vy, got.gnd, got.air,
                             got.sprint, got.hit_ent, got.hit_w, got.coll);
                end
            end
        end
    end

    // Random stall bursts on the result side until the closing part of the run.
    initial begin
        int burst;
        @(posedge rst_n);
        sink_on = 1'b1;
        while (!quiet) begin
            @(posedge clk);
            if ($urandom_range(0, 7) == 0) begin
                sink_on = 1'b0;
                burst = $urandom_range(1, 11);
                repeat (burst) @(posedge clk);
                sink_on = 1'b1;
            end
        end
        sink_on = 1'b1;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        world_w = 1600; world_h = 900; grav = 154;
        jump_v = 4608; fall_lim = 7168; walk_v = 1280;
        for (int i = 0; i < NENT; i++) begin
            px[i] = 0; py[i] = 0; pvy[i] = 0; bwid[i] = 0; bhgt[i] = 0;
            mode[i] = 0; gnd_t[i] = 0; air_t[i] = 0; jmp_t[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_physics(4095, 4095, 2047, 16383, 16383, 4095);
        test_random(150);
        set_physics(1, 1, 0, 0, 0, 0);
        test_random(100);
        set_physics(300, 200, 77, 2000, 3000, 700);
        test_random(250);
        set_physics(1600, 900, 154, 4608, 7168, 1280);
        test_random(200);
        quiet = 1'b1;
        test_random(130);

        req_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Covered loads, steps, god and walking modes, sweeps, window clamps");
        $display("over five register settings; %0d result beats compared.", results_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/peps_pkg.sv
hw/rtl/peps_sweep_unit.sv
hw/rtl/platform_entity_physics_step_top.sv
hw/rtl/peps_checker.sv
dv/tb.sv
